// ===== rtl/core/xrg_pkg.sv =====
// Shared constants, types and the xorshift step for the range generator.
package xrg_pkg;

    localparam int XRG_DATA_W = 32;
    localparam int XRG_CNT_W  = $clog2(XRG_DATA_W);

    localparam logic [XRG_DATA_W-1:0] XRG_SEED_DEFAULT = 32'h1234_5678;
    localparam int XRG_SHIFT_A = 13;
    localparam int XRG_SHIFT_B = 17;
    localparam int XRG_SHIFT_C = 5;

    typedef logic [XRG_DATA_W-1:0] xrg_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } xrg_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } xrg_div_stat_t;

    function automatic xrg_word_t xrg_advance(input xrg_word_t x_in);
        xrg_word_t x;
        x = x_in;
        x = x ^ (x << XRG_SHIFT_A);
        x = x ^ (x >> XRG_SHIFT_B);
        x = x ^ (x << XRG_SHIFT_C);
        return x;
    endfunction

endpackage

// ===== rtl/core/xrg_div_serial.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module xrg_div_serial (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  xrg_pkg::xrg_word_t    dividend,
    input  xrg_pkg::xrg_word_t    divisor,
    output xrg_pkg::xrg_div_stat_t stat,
    output xrg_pkg::xrg_word_t    remainder
);
    import xrg_pkg::*;

    xrg_word_t              rem_reg, rem_next;
    xrg_word_t              quo_reg, quo_next;
    xrg_word_t              den_reg, den_next;
    logic [XRG_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [XRG_DATA_W:0]    shifted;
    logic [XRG_DATA_W:0]    diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[XRG_DATA_W-1]};
        diff      = shifted - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // keep the trial difference when it does not borrow
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = diff[XRG_DATA_W-1:0];
            end else begin
                rem_next = shifted[XRG_DATA_W-1:0];
            end
            quo_next = {quo_reg[XRG_DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == XRG_CNT_W'(XRG_DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/xorshift_range_generator.sv =====
// Top level of the xorshift32 range generator.
//
// Input channel s_*: one transfer carries a signed inclusive range
// (s_range_low, s_range_high). Result channel m_*: one transfer per request
// with m_ranged_value, m_raw_value and m_drew_flag.
// seed_wr_en/seed_wr_data reload the generator state; a zero
// seed loads 0x12345678. Write the seed only while no request is in flight.
// A non-empty range advances the state and reduces the new value modulo
// the span in a bit-serial remainder unit, one bit per cycle: the result
// is registered once the remainder unit has run through every bit and
// finished, and the next request is taken only back in the idle state,
// so no request is taken while another is in progress. An empty range
// (high <= low) returns low via the hold state without touching the state.
// The result sits in an output register; while the receiver stalls, one
// more request finishes and waits, and s_ready stays low until it drains.
// Reset (aresetn low, synchronous) empties the result channel, stops any
// request in progress and loads the state with 0x12345678.
module xorshift_range_generator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               seed_wr_en,
    input  xrg_pkg::xrg_word_t seed_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  xrg_pkg::xrg_word_t s_range_low,
    input  xrg_pkg::xrg_word_t s_range_high,
    output logic               m_valid,
    input  logic               m_ready,
    output xrg_pkg::xrg_word_t m_ranged_value,
    output xrg_pkg::xrg_word_t m_raw_value,
    output logic               m_drew_flag
);
    import xrg_pkg::*;

    xrg_state_t    state_reg, state_next;
    xrg_word_t     gen_state_reg, gen_state_next;
    xrg_word_t     low_reg, low_next;
    xrg_word_t     raw_reg, raw_next;
    logic          drew_reg, drew_next;
    logic          span_zero_reg, span_zero_next;
    logic          m_valid_reg, m_valid_next;
    xrg_word_t     m_ranged_reg, m_ranged_next;
    xrg_word_t     m_raw_reg, m_raw_next;
    logic          m_drew_reg, m_drew_next;

    logic          accept;
    logic          range_empty;
    xrg_word_t     span;
    xrg_word_t     drawn;
    logic          out_free;
    logic          div_start;
    logic          out_load;
    xrg_word_t     offset;
    xrg_div_stat_t div_stat;
    xrg_word_t     div_rem;

    assign accept      = s_valid && s_ready;
    assign range_empty = $signed(s_range_high) <= $signed(s_range_low);
    assign span        = s_range_high - s_range_low + 1'b1;
    assign drawn       = xrg_advance(gen_state_reg);
    assign out_free    = !m_valid_reg || m_ready;

    xrg_div_serial u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (drawn),
        .divisor   (span),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = range_empty ? ST_HOLD : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                div_start = s_valid && !range_empty;
            end
            ST_DIV: begin
                out_load = div_stat.done && out_free;
            end
            ST_HOLD: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        gen_state_next = gen_state_reg;
        low_next       = low_reg;
        raw_next       = raw_reg;
        drew_next      = drew_reg;
        span_zero_next = span_zero_reg;
        if (seed_wr_en) begin
            gen_state_next = (seed_wr_data != '0) ? seed_wr_data : XRG_SEED_DEFAULT;
        end else if (accept && !range_empty) begin
            gen_state_next = drawn;
        end
        if (accept) begin
            low_next       = s_range_low;
            raw_next       = range_empty ? '0 : drawn;
            drew_next      = !range_empty;
            span_zero_next = (span == '0);
        end
    end

    always_comb begin
        offset        = span_zero_reg ? raw_reg : div_rem;
        m_valid_next  = m_valid_reg;
        m_ranged_next = m_ranged_reg;
        m_raw_next    = m_raw_reg;
        m_drew_next   = m_drew_reg;
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_ranged_next = drew_reg ? (low_reg + offset) : low_reg;
            m_raw_next    = raw_reg;
            m_drew_next   = drew_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        low_reg       <= low_next;
        raw_reg       <= raw_next;
        drew_reg      <= drew_next;
        span_zero_reg <= span_zero_next;
        m_ranged_reg  <= m_ranged_next;
        m_raw_reg     <= m_raw_next;
        m_drew_reg    <= m_drew_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gen_state_reg <= XRG_SEED_DEFAULT;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            gen_state_reg <= gen_state_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_ranged_value = m_ranged_reg;
    assign m_raw_value    = m_raw_reg;
    assign m_drew_flag    = m_drew_reg;

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("remainder unit finished outside the divide state");

    a_busy_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> state_reg == ST_DIV)
        else $error("remainder unit busy outside the divide state");

    a_state_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_state_reg != '0)
        else $error("generator state reached zero");

    a_no_draw_raw_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_drew_reg |-> m_raw_reg == '0)
        else $error("raw value nonzero on an empty range");

    a_start_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> state_reg == ST_DIV && div_stat.busy)
        else $error("divide did not start after a request transfer");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for xorshift_range_generator: directed range table, then seeded random ranges.
module tb_top;
    import xrg_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        xrg_word_t ranged;
        xrg_word_t raw;
        logic      drew;
    } draw_t;

    typedef struct packed {
        xrg_word_t lo;
        xrg_word_t hi;
        logic      typed;
        draw_t     want;
    } range_row_t;

    localparam int DIR_ROWS = 22;
    localparam range_row_t DIR_TBL [DIR_ROWS] = '{
        '{32'h0000_0005, 32'h0000_0005, 1'b1, '{32'h0000_0005, 32'h0, 1'b0}},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'h7FFF_FFFF, 32'h0, 1'b0}},
        '{32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h8000_0000, 32'h0, 1'b0}},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 32'h0, 1'b0}},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'h0, 1'b0}},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
        '{32'h0000_0000, 32'h0000_0001, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
        '{32'h8000_0000, 32'h8000_0001, 1'b0, '0},
        '{32'h7FFF_FFFE, 32'h7FFF_FFFF, 1'b0, '0},
        '{32'h8000_0000, 32'h7FFF_FFFE, 1'b0, '0},
        '{32'h8000_0001, 32'h7FFF_FFFF, 1'b0, '0},
        '{32'hFFFF_FFFB, 32'h0000_0005, 1'b0, '0},
        '{32'h0000_0000, 32'h7FFF_FFFF, 1'b0, '0},
        '{32'h8000_0000, 32'h0000_0000, 1'b0, '0},
        '{32'h0000_0000, 32'h0000_FFFF, 1'b0, '0},
        '{32'h0001_0000, 32'h0001_FFFF, 1'b0, '0},
        '{32'h0000_0064, 32'h0000_0063, 1'b1, '{32'h0000_0064, 32'h0, 1'b0}},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, '{32'h5555_5555, 32'h0, 1'b0}},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 32'h0, 1'b0}}
    };

    logic      aclk;
    logic      aresetn      = 1'b0;
    logic      seed_wr_en   = 1'b0;
    xrg_word_t seed_wr_data = '0;
    logic      s_valid      = 1'b0;
    logic      s_ready;
    xrg_word_t s_range_low  = '0;
    xrg_word_t s_range_high = '0;
    logic      m_valid;
    logic      m_ready      = 1'b0;
    xrg_word_t m_ranged_value;
    xrg_word_t m_raw_value;
    logic      m_drew_flag;

    xrg_word_t gen_state;
    draw_t     pending_draws [$];
    int        mismatch_cnt = 0;
    int        cycle_cnt    = 0;
    int        stall_left   = 0;
    bit        idle_on      = 1'b1;

    xorshift_range_generator i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .seed_wr_en    (seed_wr_en),
        .seed_wr_data  (seed_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_range_low   (s_range_low),
        .s_range_high  (s_range_high),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ranged_value(m_ranged_value),
        .m_raw_value   (m_raw_value),
        .m_drew_flag   (m_drew_flag)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic xrg_word_t xorshift_next(input xrg_word_t v);
        xrg_word_t t1;
        xrg_word_t t2;
        t1 = v ^ (v << XRG_SHIFT_A);
        t2 = t1 ^ (t1 >> XRG_SHIFT_B);
        return t2 ^ (t2 << XRG_SHIFT_C);
    endfunction

    function automatic draw_t draw_from_range(input xrg_word_t lo, input xrg_word_t hi);
        draw_t     d;
        xrg_word_t span;
        if ($signed(hi) <= $signed(lo)) begin
            d.ranged = lo;
            d.raw    = '0;
            d.drew   = 1'b0;
        end else begin
            span      = hi - lo + 32'd1;
            gen_state = xorshift_next(gen_state);
            d.raw     = gen_state;
            d.drew    = 1'b1;
            if (span == '0) begin
                d.ranged = lo + gen_state;
            end else begin
                d.ranged = lo + (gen_state % span);
            end
        end
        return d;
    endfunction

    task automatic send_range(input xrg_word_t lo, input xrg_word_t hi,
                              input logic typed, input draw_t want);
        draw_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_range_low  <= lo;
        s_range_high <= hi;
        do @(posedge aclk); while (!s_ready);
        predicted = draw_from_range(lo, hi);
        pending_draws.push_back(typed ? want : predicted);
    endtask

    task automatic write_seed(input xrg_word_t seed);
        s_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge aclk);
        seed_wr_en   <= 1'b1;
        seed_wr_data <= seed;
        @(posedge aclk);
        gen_state  = (seed != '0) ? seed : XRG_SEED_DEFAULT;
        seed_wr_en <= 1'b0;
    endtask

    task automatic pick_range(output xrg_word_t lo, output xrg_word_t hi);
        int unsigned kind;
        xrg_word_t   tmp;
        kind = $urandom_range(0, 9);
        lo   = $urandom;
        case (kind)
            0, 1, 2, 3: hi = lo + $urandom_range(1, 300);
            4: hi = lo + ((32'd1 << $urandom_range(0, 31)) - 32'd1);
            5, 6: hi = $urandom;
            7: hi = lo - $urandom_range(0, 5);
            8: begin
                lo = 32'h8000_0000 + $urandom_range(0, 3);
                hi = 32'h7FFF_FFFF - $urandom_range(0, 3);
            end
            default: begin
                hi = $urandom;
                if ($signed(hi) < $signed(lo)) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end
        endcase
    endtask

    // stall the result side in bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(1, 7) - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_draws
        draw_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_draws.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected transfer: ranged %h raw %h drew %b",
                             m_ranged_value, m_raw_value, m_drew_flag);
            end else begin
                want = pending_draws.pop_front();
                if (m_ranged_value !== want.ranged || m_raw_value !== want.raw ||
                    m_drew_flag !== want.drew) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("mismatch: expected ranged %h raw %h drew %b, got %h %h %b",
                                 want.ranged, want.raw, want.drew,
                                 m_ranged_value, m_raw_value, m_drew_flag);
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("[xorshift_range_generator] ERROR");
        $finish;
    end

    initial begin
        xrg_word_t lo;
        xrg_word_t hi;
        xrg_word_t seed;
        gen_state = XRG_SEED_DEFAULT;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (DIR_TBL[i])
            send_range(DIR_TBL[i].lo, DIR_TBL[i].hi, DIR_TBL[i].typed, DIR_TBL[i].want);
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: seed = 32'h0000_0000;
                1: seed = 32'hFFFF_FFFF;
                2: seed = 32'h0000_0001;
                3: seed = 32'h8000_0000;
                default: seed = $urandom;
            endcase
            write_seed(seed);
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;
            repeat (ITEMS_PER_PHASE) begin
                pick_range(lo, hi);
                send_range(lo, hi, 1'b0, '0);
            end
        end
        s_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("[xorshift_range_generator] OK");
        end else begin
            $display("[xorshift_range_generator] ERROR");
        end
        $finish;
    end

endmodule
